### rtl/rmfh_pkg.sv
package rmfh_pkg;

  typedef enum logic {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_GRANTED     = 4'd0,
    ST_REENTERED   = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_LOWERED     = 4'd3,
    ST_FREED       = 4'd4,
    ST_HANDOFF     = 4'd5,
    ST_BAD_RELEASE = 4'd6,
    ST_NO_TASK     = 4'd7,
    ST_QUEUE_FULL  = 4'd8,
    ST_OVERFLOW    = 4'd9
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] task_id;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  woken_task;
    logic [7:0]  owner;
    logic [15:0] nesting;
    logic [4:0]  waiting;
  } out_beat_t;

endpackage

### rtl/rmfh_wait_ram.sv
module rmfh_wait_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/recursive_mutex_fifo_handoff_core.sv
// The request beat is captured together with the wait-queue RAM read of the head
// entry; the lock update and result register follow once the output can take it.
// A new request is stalled until the current one has executed its lock update.
// A result waiting on a stalled output does not block the next request's RAM read.
// Reset clears the lock owner, recursion count and queue pointers asynchronously.
// Wait-queue RAM contents are not cleared; entries are only used after being written.
module recursive_mutex_fifo_handoff_core #(
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned WAIT_DEPTH   = 16,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmfh_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmfh_pkg::out_beat_t out_beat_o
);

  localparam int unsigned IdW   = TASK_ID_BITS;
  localparam int unsigned PtrW  = $clog2(WAIT_DEPTH);
  localparam int unsigned FillW = $clog2(WAIT_DEPTH + 1);
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(WAIT_DEPTH - 1);
  localparam logic [FillW-1:0] FullCnt = FillW'(WAIT_DEPTH);

  logic                busy_q;
  rmfh_pkg::in_beat_t  item_q;
  logic [IdW-1:0]      holder_q, holder_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [PtrW-1:0]     head_q, head_d;
  logic [PtrW-1:0]     tail_q, tail_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                out_valid_q;
  rmfh_pkg::out_beat_t out_beat_q, out_beat_d;

  logic                accept;
  logic                exec_fire;
  logic                push;
  logic [IdW-1:0]      id;
  logic [IdW+7:0]      id_ext;
  logic [IdW-1:0]      head_data;
  logic [IdW-1:0]      woken;
  rmfh_pkg::status_e   status;
  logic [IdW+7:0]      woken_ext;
  logic [IdW+7:0]      owner_ext;
  logic [COUNT_BITS+15:0] nest_ext;
  logic [FillW+4:0]    wait_ext;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign accept    = in_valid_i && !busy_q;
  assign exec_fire = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  assign id_ext = {{IdW{1'b0}}, item_q.task_id};
  assign id     = id_ext[IdW-1:0];

  rmfh_wait_ram #(
    .DEPTH (WAIT_DEPTH),
    .WIDTH (IdW)
  ) u_wait_ram (
    .clk_i     (clk_i),
    .wr_en_i   (exec_fire && push),
    .wr_addr_i (tail_q),
    .wr_data_i (id),
    .rd_en_i   (accept),
    .rd_addr_i (head_q),
    .rd_data_o (head_data)
  );

  always_comb begin
    holder_d = holder_q;
    count_d  = count_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    status   = rmfh_pkg::ST_NO_TASK;
    woken    = '0;
    push     = 1'b0;
    if (id == '0) begin
      status = rmfh_pkg::ST_NO_TASK;
    end else if (item_q.kind == rmfh_pkg::KIND_ACQUIRE) begin
      if (holder_q == id) begin
        if (&count_q) begin
          status = rmfh_pkg::ST_OVERFLOW;
        end else begin
          count_d = count_q + COUNT_BITS'(1);
          status  = rmfh_pkg::ST_REENTERED;
        end
      end else if (holder_q == '0) begin
        holder_d = id;
        status   = rmfh_pkg::ST_GRANTED;
      end else if (fill_q == FullCnt) begin
        status = rmfh_pkg::ST_QUEUE_FULL;
      end else begin
        push   = 1'b1;
        tail_d = next_ptr(tail_q);
        fill_d = fill_q + FillW'(1);
        status = rmfh_pkg::ST_QUEUED;
      end
    end else begin
      if (holder_q != id) begin
        status = rmfh_pkg::ST_BAD_RELEASE;
      end else if (count_q != '0) begin
        count_d = count_q - COUNT_BITS'(1);
        status  = rmfh_pkg::ST_LOWERED;
      end else if (fill_q == '0) begin
        holder_d = '0;
        status   = rmfh_pkg::ST_FREED;
      end else begin
        woken    = head_data;
        holder_d = head_data;
        count_d  = '0;
        head_d   = next_ptr(head_q);
        fill_d   = fill_q - FillW'(1);
        status   = rmfh_pkg::ST_HANDOFF;
      end
    end
  end

  assign woken_ext = {8'd0, woken};
  assign owner_ext = {8'd0, holder_d};
  assign nest_ext  = {16'd0, count_d};
  assign wait_ext  = {5'd0, fill_d};

  always_comb begin
    out_beat_d.status     = status;
    out_beat_d.woken_task = woken_ext[7:0];
    out_beat_d.owner      = owner_ext[7:0];
    out_beat_d.nesting    = nest_ext[15:0];
    out_beat_d.waiting    = wait_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      holder_q    <= '0;
      count_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec_fire) begin
        busy_q <= 1'b0;
      end
      if (exec_fire) begin
        holder_q    <= holder_d;
        count_q     <= count_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_beat_i;
    end
    if (exec_fire) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt)
    else $error("Wait queue fill exceeds its depth.");

  a_free_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    holder_q == '0 |-> count_q == '0)
    else $error("Free lock carries a recursion count.");

  a_waiters_need_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != '0 |-> holder_q != '0)
    else $error("Tasks are queued on a free lock.");

  a_handoff_woken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_beat_q.status == rmfh_pkg::ST_HANDOFF |->
      out_beat_q.woken_task != 8'd0 && out_beat_q.woken_task == out_beat_q.owner)
    else $error("Handoff beat does not name the new owner.");

endmodule
